/* design/pcodec_pkg.sv */
package pcodec_pkg;

  // Default number of jobs buffered between the front and the back.
  localparam int unsigned QueueDepthDef = 2;

  // Maximum result bytes produced by one source byte.
  localparam int unsigned MaxBytes = 3;

  localparam logic [7:0] PctChar = 8'h25;

  typedef enum logic {
    MODE_ENCODE = 1'b0,
    MODE_DECODE = 1'b1
  } codec_mode_e;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_PCT  = 2'd1,
    PH_HEX  = 2'd2
  } decode_phase_e;

  // One job: the result bytes caused by one source byte, in order.
  typedef struct packed {
    logic [MaxBytes-1:0][7:0] bytes;
    logic [1:0]               cnt;
    logic                     last;
  } job_t;

  // Returns {is_hex, nibble value}.
  function automatic logic [4:0] hex_decode(logic [7:0] c);
    logic [4:0] r;
    begin
      case (c) inside
        [8'h30:8'h39]:               r = {1'b1, c[3:0]};
        [8'h41:8'h46], [8'h61:8'h66]: r = {1'b1, c[3:0] + 4'd9};
        default:                     r = 5'd0;
      endcase
      return r;
    end
  endfunction

  function automatic logic is_alnum(logic [7:0] c);
    logic r;
    begin
      case (c) inside
        [8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]: r = 1'b1;
        default:                                     r = 1'b0;
      endcase
      return r;
    end
  endfunction

  // Upper-case ASCII hex digit for a nibble.
  function automatic logic [7:0] hex_char(logic [3:0] nib);
    logic [7:0] r;
    begin
      if (nib < 4'd10) begin
        r = {4'h3, nib};
      end else begin
        r = 8'h37 + {4'h0, nib};
      end
      return r;
    end
  endfunction

endpackage

/* design/percent_codec.sv */
// A byte's first result beat is registered in the job queue, then in the output register.
// Throughput: one source byte per cycle while each byte yields at most one result and the
// receiver is ready; the back end drains one result beat per cycle while it is ready.
// Reset: asynchronous, active low; selects encode mode, clears the decode state, the job
// queue and the output valid flag.
module percent_codec
  import pcodec_pkg::*;
#(
  parameter int unsigned QueueDepth = QueueDepthDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       codec_mode_we_i,
  input  logic       codec_mode_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  input  logic       last_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       last_out_o
);

  // The front end classifies each source byte and turns it into a job that lists its
  // result bytes. It holds the mode register and the decode state, so a byte is fully
  // judged in the cycle it is accepted. Bytes that produce nothing, such as a '%' that
  // opens an escape, are consumed without a job.
  logic push_valid, push_ready;
  job_t push_job;

  // The back end pulls jobs from the queue and sends their bytes one beat at a time
  // through an output register, so the front end keeps accepting until the queue fills.
  logic pop_valid, pop_ready;
  job_t pop_job;

  pcodec_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .codec_mode_we_i(codec_mode_we_i),
    .codec_mode_i   (codec_mode_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .data_byte_i    (data_byte_i),
    .last_byte_i    (last_byte_i),
    .push_valid_o   (push_valid),
    .push_job_o     (push_job),
    .push_ready_i   (push_ready)
  );

  pcodec_queue #(
    .Depth(QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(push_valid),
    .push_ready_o(push_ready),
    .push_job_i  (push_job),
    .pop_valid_o (pop_valid),
    .pop_ready_i (pop_ready),
    .pop_job_o   (pop_job)
  );

  pcodec_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .job_valid_i(pop_valid),
    .job_ready_o(pop_ready),
    .job_i      (pop_job),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_byte_o (out_byte_o),
    .last_out_o (last_out_o)
  );

  // A last byte always leaves at least one result, so it must always produce a job.
  a_last_makes_job : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && last_byte_i) |-> push_valid)
    else $error("last byte accepted without a job");

  // The back end relies on every queued job holding at least one byte.
  a_job_not_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_valid |-> (pop_job.cnt != 2'd0))
    else $error("empty job in queue");

  // Every three-byte job, such as an escaped byte in encode mode, starts with a '%'.
  a_escape_len : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_valid && (push_job.cnt == 2'd3) && (push_job.bytes[0] != PctChar)) |-> 1'b0)
    else $error("three-byte job does not start with percent");

endmodule

/* design/pcodec_front.sv */
module pcodec_front
  import pcodec_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       codec_mode_we_i,
  input  logic       codec_mode_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  input  logic       last_byte_i,
  output logic       push_valid_o,
  output job_t       push_job_o,
  input  logic       push_ready_i
);

  codec_mode_e   mode_q;
  decode_phase_e phase_q, phase_d;
  logic [7:0]    held_q, held_d;

  job_t       job;
  logic [1:0] n;
  logic       rejudge;
  logic [4:0] hv;
  logic [4:0] hi;
  logic       accept;

  assign in_ready_o = push_ready_i;
  assign accept     = in_valid_i && push_ready_i;

  always_comb begin
    phase_d = phase_q;
    held_d  = held_q;
    job     = '0;
    n       = 2'd0;
    rejudge = 1'b0;
    hv      = hex_decode(data_byte_i);
    hi      = hex_decode(held_q);

    if (mode_q == MODE_ENCODE) begin
      if (is_alnum(data_byte_i)) begin
        job.bytes[0] = data_byte_i;
        n = 2'd1;
      end else begin
        job.bytes[0] = PctChar;
        job.bytes[1] = hex_char(data_byte_i[7:4]);
        job.bytes[2] = hex_char(data_byte_i[3:0]);
        n = 2'd3;
      end
    end else begin
      case (phase_q)
        PH_PCT: begin
          if (hv[4]) begin
            held_d  = data_byte_i;
            phase_d = PH_HEX;
          end else begin
            job.bytes[n] = PctChar;
            n = n + 2'd1;
            phase_d = PH_IDLE;
            rejudge = 1'b1;
          end
        end
        PH_HEX: begin
          if (hv[4]) begin
            job.bytes[n] = {hi[3:0], hv[3:0]};
            n = n + 2'd1;
            phase_d = PH_IDLE;
          end else begin
            job.bytes[n] = PctChar;
            n = n + 2'd1;
            job.bytes[n] = held_q;
            n = n + 2'd1;
            phase_d = PH_IDLE;
            rejudge = 1'b1;
          end
        end
        default: begin
          phase_d = PH_IDLE;
          rejudge = 1'b1;
        end
      endcase

      if (rejudge) begin
        if (data_byte_i == PctChar) begin
          phase_d = PH_PCT;
        end else begin
          job.bytes[n] = data_byte_i;
          n = n + 2'd1;
        end
      end

      // End of string: pending characters go out raw.
      if (last_byte_i) begin
        if (phase_d == PH_PCT) begin
          job.bytes[n] = PctChar;
          n = n + 2'd1;
        end else if (phase_d == PH_HEX) begin
          job.bytes[n] = PctChar;
          n = n + 2'd1;
          job.bytes[n] = held_d;
          n = n + 2'd1;
        end
        phase_d = PH_IDLE;
      end
    end

    job.cnt  = n;
    job.last = last_byte_i;
  end

  assign push_valid_o = in_valid_i && (n != 2'd0);
  assign push_job_o   = job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_ENCODE;
      phase_q <= PH_IDLE;
      held_q  <= 8'd0;
    end else if (codec_mode_we_i) begin
      mode_q  <= codec_mode_e'(codec_mode_i);
      phase_q <= PH_IDLE;
      held_q  <= 8'd0;
    end else if (accept && (mode_q == MODE_DECODE)) begin
      phase_q <= phase_d;
      held_q  <= held_d;
    end
  end

endmodule

/* design/pcodec_queue.sv */
module pcodec_queue
  import pcodec_pkg::*;
#(
  parameter int unsigned Depth = QueueDepthDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  job_t push_job_i,
  output logic pop_valid_o,
  input  logic pop_ready_i,
  output job_t pop_job_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            push, pop;

  assign push_ready_o = (cnt_q != CntW'(Depth));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_job_o    = mem_q[rd_ptr_q];

  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

endmodule

/* design/pcodec_back.sv */
module pcodec_back
  import pcodec_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       job_valid_i,
  output logic       job_ready_o,
  input  job_t       job_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       last_out_o
);

  logic [1:0] idx_q, idx_d;
  logic       out_valid_q, out_valid_d;
  logic [7:0] out_byte_q;
  logic       last_out_q;
  logic       load, final_byte;

  // The output register takes a new beat when it is empty or being drained.
  assign load       = job_valid_i && (!out_valid_q || out_ready_i);
  assign final_byte = (idx_q == job_i.cnt - 2'd1);
  assign job_ready_o = load && final_byte;

  always_comb begin
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (load) begin
      out_valid_d = 1'b1;
      idx_d       = final_byte ? 2'd0 : idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_byte_q <= job_i.bytes[idx_q];
      last_out_q <= job_i.last && final_byte;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign last_out_o  = last_out_q;

endmodule

/* verif/percent_codec_tb.sv */
`timescale 1ns / 1ps

module percent_codec_tb;
  import pcodec_pkg::*;

  // Cycles without any accepted beat before the run is declared hung. The longest
  // legitimate quiet stretch is the forced receiver hold-off below.
  localparam int StallLimit = 2000;
  // Receiver hold-off length, long enough to back the block up into its input.
  localparam int LongHold = 300;
  // Extra cycles after the last expected beat before the mode register may be
  // touched or the run may end. A byte that yields no result can still be in flight.
  localparam int SettleCycles = 12;
  localparam int SegmentItems = 40;

  // One source beat and one converted beat.
  typedef struct packed {
    logic [7:0] ch;
    logic       tail;
  } src_beat_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       tail;
  } out_beat_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       codec_mode_we_i = 1'b0;
  logic       codec_mode_i = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  logic [7:0] data_byte_i = 8'h00;
  logic       last_byte_i = 1'b0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic [7:0] out_byte_o;
  logic       last_out_o;

  // Source bytes waiting to be offered, and converted bytes still owed by the block.
  src_beat_t pending_src[$];
  out_beat_t expected_out[$];

  // Shadow copy of the codec state, kept in step with every accepted source beat.
  codec_mode_e   model_mode = MODE_ENCODE;
  decode_phase_e model_phase = PH_IDLE;
  logic [7:0]    model_held = 8'h00;

  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  bit  hold_arm = 1'b0;
  bit  hold_used = 1'b0;
  int  hold_left = 0;
  int  mismatches = 0;
  int  src_count = 0;
  int  quiet_cycles = 0;
  string hex_chars = "0123456789ABCDEF";

  percent_codec i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .codec_mode_we_i(codec_mode_we_i),
    .codec_mode_i   (codec_mode_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .data_byte_i    (data_byte_i),
    .last_byte_i    (last_byte_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_byte_o     (out_byte_o),
    .last_out_o     (last_out_o)
  );

  always #4 clk_i = ~clk_i;

  // Value of an ASCII hex digit of either case, or -1 for any other byte.
  function automatic int nibble_value(logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
    if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h41 + 10;
    if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h61 + 10;
    return -1;
  endfunction

  // Letters and digits are the only bytes that pass the encoder untouched.
  function automatic bit is_plain(logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
           (c >= 8'h61 && c <= 8'h7A);
  endfunction

  function automatic logic [7:0] upper_hex(logic [3:0] nib);
    return hex_chars[nib];
  endfunction

  // Works out the converted beats caused by one source beat and queues them.
  // Decode keeps a '%' and then one hex digit pending; a byte that breaks the
  // sequence releases what is pending and is then treated as a fresh byte.
  task automatic codec_predict(input logic [7:0] c, input logic tail);
    logic [7:0] res[$];
    int         hv;
    int         hi;
    bit         fresh;
    out_beat_t  ob;
    fresh = 1'b0;
    if (model_mode == MODE_ENCODE) begin
      if (is_plain(c)) begin
        res = {res, c};
      end else begin
        res = {res, PctChar};
        res = {res, upper_hex(c[7:4])};
        res = {res, upper_hex(c[3:0])};
      end
    end else begin
      hv = nibble_value(c);
      case (model_phase)
        PH_PCT: begin
          if (hv >= 0) begin
            model_held = c;
            model_phase = PH_HEX;
          end else begin
            res = {res, PctChar};
            model_phase = PH_IDLE;
            fresh = 1'b1;
          end
        end
        PH_HEX: begin
          if (hv >= 0) begin
            hi = nibble_value(model_held);
            if (hi < 0) hi = 0;
            res = {res, 8'((hi << 4) | hv)};
            model_phase = PH_IDLE;
          end else begin
            res = {res, PctChar};
            res = {res, model_held};
            model_phase = PH_IDLE;
            fresh = 1'b1;
          end
        end
        default: begin
          // The unused phase encoding behaves like idle.
          model_phase = PH_IDLE;
          fresh = 1'b1;
        end
      endcase
      if (fresh) begin
        if (c == PctChar) begin
          model_phase = PH_PCT;
        end else begin
          res = {res, c};
        end
      end
      // The final byte of a string flushes whatever is still pending, raw.
      if (tail) begin
        if (model_phase == PH_PCT) begin
          res = {res, PctChar};
        end else if (model_phase == PH_HEX) begin
          res = {res, PctChar};
          res = {res, model_held};
        end
        model_phase = PH_IDLE;
      end
    end
    foreach (res[i]) begin
      ob.ch = res[i];
      ob.tail = tail && (i == res.size() - 1);
      expected_out = {expected_out, ob};
    end
  endtask

  // Prints one line per mismatch and counts it.
  task automatic report_mismatch(input string what);
    $display("%0t ns: mismatch: %s", $time, what);
    mismatches++;
  endtask

  // Sender: offers the next pending beat whenever the slot is free and the idle
  // dice allow it. Accepted beats feed the predictor on the edge they are taken.
  always @(posedge clk_i) begin : sender
    src_beat_t nxt;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        codec_predict(data_byte_i, last_byte_i);
      end
      if (!in_valid_i || in_ready_o) begin
        if (pending_src.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = pending_src.pop_front();
          in_valid_i <= 1'b1;
          data_byte_i <= nxt.ch;
          last_byte_i <= nxt.tail;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off that is armed by the stimulus
  // and counted down here, during which the sender keeps offering bytes.
  always @(posedge clk_i) begin
    if (hold_arm && !hold_used) begin
      hold_used <= 1'b1;
      hold_left <= LongHold;
      out_ready_i <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Compares every converted beat with the oldest owed one, field by field.
  always @(posedge clk_i) begin : monitor
    out_beat_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_out.size() == 0) begin
        report_mismatch($sformatf("unexpected beat %h last %b", out_byte_o, last_out_o));
      end else begin
        want = expected_out.pop_front();
        if (out_byte_o !== want.ch) begin
          report_mismatch($sformatf("out_byte %h, want %h", out_byte_o, want.ch));
        end
        if (last_out_o !== want.tail) begin
          report_mismatch($sformatf("last_out %b, want %b", last_out_o, want.tail));
        end
      end
    end
  end

  // Watchdog on forward progress: any accepted beat or register write counts.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || codec_mode_we_i) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= StallLimit) begin
      $display("percent_codec_tb NOT OK");
      $finish;
    end
  end

  task automatic push_beat(input logic [7:0] c, input logic tail);
    src_beat_t sb;
    sb.ch = c;
    sb.tail = tail;
    pending_src = {pending_src, sb};
    src_count++;
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_beat(s[i], i == s.len() - 1);
  endtask

  function automatic logic [7:0] random_hex_char();
    int nib;
    nib = $urandom_range(15);
    if (nib < 10) return 8'(nib + 'h30);
    if ($urandom_range(1) != 0) return 8'(nib - 10 + 'h61);
    return 8'(nib - 10 + 'h41);
  endfunction

  function automatic logic [7:0] random_non_hex();
    logic [7:0] c;
    do c = 8'($urandom_range(255)); while (nibble_value(c) >= 0);
    return c;
  endfunction

  function automatic logic [7:0] random_plain();
    case ($urandom_range(2))
      0:       return 8'($urandom_range(9) + 'h30);
      1:       return 8'($urandom_range(25) + 'h41);
      default: return 8'($urandom_range(25) + 'h61);
    endcase
  endfunction

  // Encode strings mix letters and digits with arbitrary bytes.
  task automatic push_encode_string();
    int n;
    n = $urandom_range(6, 1);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(2) == 0) push_beat(random_plain(), i == n - 1);
      else push_beat(8'($urandom_range(255)), i == n - 1);
    end
  endtask

  // Decode strings are mostly well-formed escapes with random digits; the rest is plain text,
  // stray bytes, sequences broken after one or two characters and dangling escapes.
  task automatic push_decode_string();
    logic [7:0] txt[$];
    int         n;
    n = $urandom_range(4, 1);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(9)) inside
        [0:5]: begin
          txt = {txt, PctChar};
          txt = {txt, random_hex_char()};
          txt = {txt, random_hex_char()};
        end
        6: begin
          if ($urandom_range(1) != 0) txt = {txt, random_plain()};
          else txt = {txt, 8'($urandom_range(255))};
        end
        7: begin
          txt = {txt, PctChar};
          txt = {txt, random_non_hex()};
        end
        8: begin
          txt = {txt, PctChar};
          txt = {txt, random_hex_char()};
          txt = {txt, random_non_hex()};
        end
        default: begin
          // A dangling escape: flushed raw at the end of the string, or broken
          // by whatever the next piece starts with.
          txt = {txt, PctChar};
          if ($urandom_range(1) != 0) txt = {txt, random_hex_char()};
        end
      endcase
    end
    foreach (txt[i]) push_beat(txt[i], i == txt.size() - 1);
  endtask

  // Waits until every queued byte is taken and every owed beat has come out,
  // then lets the block settle.
  task automatic wait_drained();
    do @(posedge clk_i); while (pending_src.size() != 0 || in_valid_i || expected_out.size() != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // A mode write also clears the decode state, so it is only issued when idle.
  task automatic write_mode(input codec_mode_e m);
    wait_drained();
    codec_mode_we_i <= 1'b1;
    codec_mode_i <= m;
    @(posedge clk_i);
    codec_mode_we_i <= 1'b0;
    model_mode = m;
    model_phase = PH_IDLE;
    model_held = 8'h00;
  endtask

  // One stretch of random traffic in one mode under one idling profile. With
  // pressure on, encode traffic rides through the long receiver hold-off, and
  // the sender stops halfway until the block has delivered everything.
  task automatic run_segment(input codec_mode_e m, input int idle, input int stall,
                             input bit pressure);
    int goal;
    write_mode(m);
    send_idle_pct <= idle;
    recv_stall_pct <= stall;
    if (pressure && m == MODE_ENCODE) hold_arm <= 1'b1;
    goal = src_count + (pressure ? SegmentItems / 2 : SegmentItems);
    while (src_count < goal) begin
      if (m == MODE_ENCODE) push_encode_string();
      else push_decode_string();
    end
    if (pressure) begin
      wait_drained();
      goal = src_count + SegmentItems / 2;
      while (src_count < goal) begin
        if (m == MODE_ENCODE) push_encode_string();
        else push_decode_string();
      end
    end
  endtask

  initial begin
    int idle_tab[4];
    int stall_tab[4];
    idle_tab = '{0, 57, 0, 21};
    stall_tab = '{0, 0, 57, 21};

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Encode from reset: the bytes just outside every letter and digit range,
    // one letter, and both ends of the byte range.
    push_beat(8'h00, 1'b0);
    push_beat(8'h2F, 1'b0);
    push_beat(8'h3A, 1'b0);
    push_beat(8'h40, 1'b0);
    push_beat(8'h5B, 1'b0);
    push_beat(8'h60, 1'b0);
    push_beat(8'h7B, 1'b0);
    push_beat(8'h7A, 1'b0);
    push_beat(8'hFF, 1'b1);

    // Decode: a good escape with a lower-case digit, a '%' broken at once, one
    // broken after its first digit, a lone '%' as the last byte, a string ending
    // after one digit, and a '%' that breaks another '%'.
    write_mode(MODE_DECODE);
    push_text("%4a");
    push_text("%G");
    push_text("%4Z");
    push_text("%");
    push_text("%F");
    push_text("%%");

    // A mode write in the middle of an escape drops the pending '%'.
    push_beat(PctChar, 1'b0);
    write_mode(MODE_DECODE);
    push_text("41");

    // Random traffic, each idling profile in both modes.
    for (int k = 0; k < 4; k++) begin
      run_segment(MODE_ENCODE, idle_tab[k], stall_tab[k], k == 0);
      run_segment(MODE_DECODE, idle_tab[k], stall_tab[k], k == 0);
    end

    wait_drained();
    if (mismatches == 0) begin
      $display("percent_codec_tb OK");
    end else begin
      $display("percent_codec_tb NOT OK");
    end
    $finish;
  end

endmodule
